[hw/rtl/ebed_pkg.sv]
// Shared constants and register codes for the EMA baseline event detector.
package ebed_pkg;

  // Sample width default and fixed field widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int FRAC_SHIFT      = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 8;
  localparam int OUT_W           = 16;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA      = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP     = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY = 8'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RST  = 16'd160;
  localparam logic [CFG_W-1:0] ALPHA_RST      = 16'd1311;
  localparam logic [CFG_W-1:0] WARMUP_RST     = 16'd5000;
  localparam logic [CFG_W-1:0] REFRACTORY_RST = 16'd10000;

endpackage

[hw/rtl/ema_baseline_event_detector.sv]
// EMA baseline tracker with threshold event detection on a sample stream.
// A sample moves from the input register into the result register, where m_tvalid offers its result.
// One sample per cycle while m_tready does not stall the result; the baseline multiply-add is combinational.
// One extra sample is held in the input register while a result waits on m_tready.
// Reset (rst, synchronous, active high) clears both stages, the seed flag and event state,
// and loads the register defaults; the next sample after reset seeds the baseline.
module ema_baseline_event_detector
  import ebed_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // fields from bit 0: magnitude[SAMPLE_BITS], time_ms[32], zero padding to bytes
  input  logic [((SAMPLE_BITS + TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // fields from bit 0: deviation[16], event_peak[16], event_duration[32]
  output logic [63:0]           m_tdata,
  // fields from bit 0: event_started[1], event_closed[1]
  output logic [1:0]            m_tuser,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Baseline is the sample with FRAC_SHIFT fraction bits
  localparam int BW = SAMPLE_BITS + FRAC_SHIFT;
  localparam int PW = BW + CFG_W;
  localparam logic [BW:0]   DEV_HALF  = (BW + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic [PW-1:0] STEP_HALF = PW'(1) << (FRAC_SHIFT - 1);
  localparam logic [BW-1:0] BASE_MAX  = {{SAMPLE_BITS{1'b1}}, {FRAC_SHIFT{1'b0}}};

  // configuration registers
  logic [CFG_W-1:0] trigger_threshold;
  logic [CFG_W-1:0] smoothing_alpha;
  logic [CFG_W-1:0] warmup_time;
  logic [CFG_W-1:0] refractory_time;

  // input register
  logic                   in_full;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic [TIME_W-1:0]      in_time;

  // detector state
  logic                   seeded;
  logic [BW-1:0]          baseline;
  logic [TIME_W-1:0]      first_time;
  logic                   event_open;
  logic [SAMPLE_BITS-1:0] peak_so_far;
  logic [TIME_W-1:0]      start_time;
  logic [TIME_W-1:0]      last_over_time;

  // result register
  logic [OUT_W-1:0]  out_dev;
  logic              out_started;
  logic              out_closed;
  logic [OUT_W-1:0]  out_peak;
  logic [TIME_W-1:0] out_dur;

  logic advance;

  // datapath
  logic [BW-1:0]          mag_full;
  logic                   up;
  logic [BW-1:0]          diff;
  logic [BW:0]            dev_round;
  logic [SAMPLE_BITS:0]   dev_wide;
  logic [SAMPLE_BITS-1:0] dev;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          prod_round;
  logic [BW-1:0]          step;
  logic [BW-1:0]          baseline_next;
  logic [TIME_W-1:0]      since_seed;
  logic [TIME_W-1:0]      since_start;
  logic                   warm;
  logic                   over;
  logic                   close_now;
  logic [SAMPLE_BITS-1:0] peak_next;
  logic [TIME_W-1:0]      last_over_next;
  logic [TIME_W-1:0]      dur_next;

  // the input register empties whenever the result register can take its sample
  assign advance   = in_full && (!m_tvalid || m_tready);
  assign s_tready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    mag_full   = {in_mag, {FRAC_SHIFT{1'b0}}};
    up         = mag_full >= baseline;
    diff       = up ? (mag_full - baseline) : (baseline - mag_full);
    // deviation rounded half up, saturated to the sample range
    dev_round  = {1'b0, diff} + DEV_HALF;
    dev_wide   = dev_round[BW:FRAC_SHIFT];
    dev        = dev_wide[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : dev_wide[SAMPLE_BITS-1:0];
    // EMA step never exceeds diff, so the baseline stays between old value and sample
    prod       = PW'(diff) * PW'(smoothing_alpha);
    prod_round = prod + STEP_HALF;
    step       = prod_round[PW-1:FRAC_SHIFT];
    baseline_next = up ? (baseline + step) : (baseline - step);

    since_seed  = in_time - first_time;
    since_start = in_time - start_time;
    warm        = since_seed >= TIME_W'(warmup_time);
    over        = TIME_W'(dev) > TIME_W'(trigger_threshold);
    close_now   = since_start >= TIME_W'(refractory_time);
    // the closing sample still counts toward peak and last over-threshold time
    peak_next      = (dev > peak_so_far) ? dev : peak_so_far;
    last_over_next = over ? in_time : last_over_time;
    dur_next       = last_over_next - start_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_threshold <= THRESHOLD_RST;
      smoothing_alpha   <= ALPHA_RST;
      warmup_time       <= WARMUP_RST;
      refractory_time   <= REFRACTORY_RST;
      in_full           <= 1'b0;
      m_tvalid          <= 1'b0;
      seeded            <= 1'b0;
      event_open        <= 1'b0;
      baseline          <= '0;
      first_time        <= '0;
      peak_so_far       <= '0;
      start_time        <= '0;
      last_over_time    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_THRESHOLD:  trigger_threshold <= cfg_data[CFG_W-1:0];
          REG_ALPHA:      smoothing_alpha   <= cfg_data[CFG_W-1:0];
          REG_WARMUP:     warmup_time       <= cfg_data[CFG_W-1:0];
          REG_REFRACTORY: refractory_time   <= cfg_data[CFG_W-1:0];
          default: ;
        endcase
      end

      // input stage
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // result stage
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (advance) begin
        if (!seeded) begin
          // seed sample: load the baseline, report all zeros
          seeded     <= 1'b1;
          baseline   <= mag_full;
          first_time <= in_time;
        end else begin
          baseline <= baseline_next;
          if (warm) begin
            if (event_open) begin
              peak_so_far    <= peak_next;
              last_over_time <= last_over_next;
              if (close_now) begin
                event_open  <= 1'b0;
                peak_so_far <= '0;
              end
            end else if (over) begin
              event_open     <= 1'b1;
              start_time     <= in_time;
              last_over_time <= in_time;
              peak_so_far    <= dev;
            end
          end
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mag  <= s_tdata[SAMPLE_BITS-1:0];
      in_time <= s_tdata[SAMPLE_BITS +: TIME_W];
    end
    if (advance) begin
      out_dev     <= seeded ? OUT_W'(dev) : '0;
      out_started <= seeded && warm && !event_open && over;
      out_closed  <= seeded && warm && event_open && close_now;
      out_peak    <= (seeded && warm && event_open && close_now) ? OUT_W'(peak_next) : '0;
      out_dur     <= (seeded && warm && event_open && close_now) ? dur_next : '0;
    end
  end

  assign m_tdata = {out_dur, out_peak, out_dev};
  assign m_tuser = {out_closed, out_started};

  // seed sample gives an all-zero result
  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && !seeded) |=> (m_tdata == '0 && m_tuser == '0))
    else $error("seed sample result not zero");

  // an event cannot open and close on the same sample
  a_start_close_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("event started and closed together");

  // opening an event is always reported with the sample that opened it
  a_start_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(event_open) |-> (m_tvalid && m_tuser[0]))
    else $error("event opened without start flag");

  // baseline never passes the largest sample
  a_baseline_range: assert property (@(posedge clk) disable iff (rst)
    seeded |-> (baseline <= BASE_MAX))
    else $error("baseline out of range");

  // input register holds while the result stage is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full");

endmodule
